// ===== sv/cbd_pkg.sv =====
package cbd_pkg;

  // width of the chunk size accumulator and data countdown
  localparam int SIZE_BITS = 32;

  // result kind codes
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // characters with a role in the size line
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // decoder phase, one-hot
  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_LINE  = 7'b0000010,
    PH_DATA  = 7'b0000100,
    PH_TRL1  = 7'b0001000,
    PH_TRL2  = 7'b0010000,
    PH_DONE  = 7'b0100000,
    PH_ERROR = 7'b1000000
  } phase_t;

  // one byte handed to the decoder core
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       fin;
  } cbd_req_t;

  // what the core produced for that byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
  } cbd_res_t;

  // hex digit decode: {is_digit, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
      [8'h41:8'h46]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  // space, tab, lf, vt, ff, cr
  function automatic logic is_blank(input logic [7:0] c);
    logic b;
    b = 1'b0;
    case (c) inside
      8'h20, [8'h09:8'h0D]: b = 1'b1;
      default:              b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/cbd_core.sv =====
module cbd_core (
  input  logic               clk,
  input  logic               rst,
  input  cbd_pkg::cbd_req_t  req,
  output cbd_pkg::cbd_res_t  res
);

  cbd_pkg::phase_t                phase, phase_next;
  logic [cbd_pkg::SIZE_BITS-1:0]  bytes_left, bytes_left_next;
  logic                           prev_was_cr, prev_was_cr_next;
  logic                           digit_seen, digit_seen_next;
  logic                           digits_done, digits_done_next;

  logic [4:0] hex;
  logic       line_go;

  assign hex = cbd_pkg::hex_decode(req.data);

  // per-byte state update
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    prev_was_cr_next = prev_was_cr;
    digit_seen_next  = digit_seen;
    digits_done_next = digits_done;
    line_go          = 1'b0;
    res              = '0;
    res.kind         = cbd_pkg::KIND_DATA;

    if (req.fire) begin
      case (phase)
        cbd_pkg::PH_START, cbd_pkg::PH_LINE: begin
          phase_next = cbd_pkg::PH_LINE;
          line_go    = 1'b1;
          // pending cr: either ends the line or acts as a blank
          if (prev_was_cr) begin
            prev_was_cr_next = 1'b0;
            if (req.data == cbd_pkg::CHAR_LF) begin
              line_go = 1'b0;
              if (!digit_seen) begin
                phase_next = cbd_pkg::PH_ERROR;
              end else if (bytes_left == '0) begin
                phase_next = cbd_pkg::PH_DONE;
              end else begin
                phase_next = cbd_pkg::PH_DATA;
              end
              digit_seen_next  = 1'b0;
              digits_done_next = 1'b0;
            end else begin
              digits_done_next = digits_done | digit_seen;
            end
          end
          // size line character
          if (line_go) begin
            if (req.data == cbd_pkg::CHAR_CR) begin
              prev_was_cr_next = 1'b1;
            end else if (!digits_done_next) begin
              if (hex[4]) begin
                if (bytes_left[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_next = cbd_pkg::PH_ERROR;
                end else begin
                  bytes_left_next = {bytes_left[cbd_pkg::SIZE_BITS-5:0], hex[3:0]};
                  digit_seen_next = 1'b1;
                end
              end else if (cbd_pkg::is_blank(req.data)) begin
                if (digit_seen) begin
                  digits_done_next = 1'b1;
                end
              end else if (!digit_seen) begin
                phase_next = cbd_pkg::PH_ERROR;
              end else begin
                digits_done_next = 1'b1;
              end
            end
          end
        end
        cbd_pkg::PH_DATA: begin
          res.valid = !req.fin;
          res.data  = req.data;
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - cbd_pkg::SIZE_BITS'(1);
          end
          if (bytes_left_next == '0) begin
            phase_next = cbd_pkg::PH_TRL1;
          end
        end
        cbd_pkg::PH_TRL1: begin
          phase_next = cbd_pkg::PH_TRL2;
        end
        cbd_pkg::PH_TRL2: begin
          phase_next = cbd_pkg::PH_START;
        end
        default: begin
        end
      endcase

      // flagged byte reports status and rearms for a new body
      if (req.fin) begin
        res.valid = 1'b1;
        res.data  = 8'd0;
        res.kind  = (phase_next == cbd_pkg::PH_START || phase_next == cbd_pkg::PH_DONE)
                    ? cbd_pkg::KIND_OK : cbd_pkg::KIND_ERR;
        phase_next       = cbd_pkg::PH_START;
        bytes_left_next  = '0;
        prev_was_cr_next = 1'b0;
        digit_seen_next  = 1'b0;
        digits_done_next = 1'b0;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cbd_pkg::PH_START;
      bytes_left  <= '0;
      prev_was_cr <= 1'b0;
      digit_seen  <= 1'b0;
      digits_done <= 1'b0;
    end else begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      prev_was_cr <= prev_was_cr_next;
      digit_seen  <= digit_seen_next;
      digits_done <= digits_done_next;
    end
  end

endmodule

// ===== sv/chunked_body_decoder_top.sv =====
// Chunked body decoder: takes the bytes of a chunk-encoded body and
// gives the decoded data bytes (kind 0) followed by one status (kind 1 ok,
// kind 2 error) for the byte flagged final_byte. A byte is held in an input
// register, decoded in a single pass against the chunk state, and its result
// lands in the output register when the byte moves on. A new byte can enter
// the input register as the held one moves on, so bytes flow without a gap
// while the output is not stalled; a stall on a valid output holds the input
// register, and the input side stalls only while that register is full and
// cannot move on.
// On an error status the consumer drops the data bytes already delivered.
module chunked_body_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] body_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_fin;
  logic              advance;
  logic              in_take;
  cbd_pkg::cbd_req_t req;
  cbd_pkg::cbd_res_t res;

  // handshake: input register moves on when the output register is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  assign req.fire = advance;
  assign req.data = in_byte;
  assign req.fin  = in_fin;

  cbd_core u_core (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= body_byte;
      in_fin  <= final_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_byte <= res.data;
      kind     <= res.kind;
    end
  end

endmodule

// ===== sv/cbd_checker.sv =====
module cbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] body_byte,
  input logic       final_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] kind
);

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(body_byte) && $stable(final_byte))
    else $error("stalled request changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind))
    else $error("stalled result changed");

  // status results carry a zero byte
  a_status_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != cbd_pkg::KIND_DATA |-> out_byte == 8'd0)
    else $error("status with nonzero byte");

  // a final byte yields a status once the output moves
  a_final_status: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && final_byte) ##1 !out_stall
    |=> out_valid && kind != cbd_pkg::KIND_DATA)
    else $error("final byte gave no status");

  // after reset nothing is pending
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .body_byte  (body_byte),
  .final_byte (final_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .kind       (kind)
);
